@@ design/fqd_pkg.sv @@
package fqd_pkg;

  // Depth of the header buffer and the width of an index into it.
  localparam int HdrBytes = 63;
  localparam int HdrAw    = $clog2(HdrBytes);

  localparam logic [7:0] CharNl    = 8'd10;
  localparam logic [7:0] CharSpace = 8'd32;
  localparam logic [7:0] CharColon = 8'd58;
  localparam logic [7:0] CharFlag  = 8'd89;

  // Space and colon counts saturate here.
  localparam logic [1:0] CountSat = 2'd2;

  typedef enum logic [1:0] {
    FlagEmpty = 2'd0,
    FlagY     = 2'd1,
    FlagOther = 2'd2
  } flag_e;

  typedef struct packed {
    logic [1:0] spaces;
    logic [1:0] colons;
    flag_e      flag;
  } hdr_scan_t;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StSend,
    StTail
  } fqd_state_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } fqd_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       header_overflow;
    logic       last;
  } fqd_out_t;

endpackage

@@ design/fqd_hdr_mem.sv @@
module fqd_hdr_mem
  import fqd_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [HdrAw-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [HdrAw-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [HdrBytes];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/fqd_scan.sv @@
module fqd_scan
  import fqd_pkg::*;
(
  input  logic [7:0] data_byte_i,
  input  hdr_scan_t  scan_i,
  output hdr_scan_t  scan_o,
  output logic       drop_cur_o,
  output logic       drop_nxt_o
);

  function automatic logic flag_set(hdr_scan_t s);
    return (s.spaces == 2'd1) && (s.colons != 2'd0) && (s.flag == FlagY);
  endfunction

  always_comb begin
    scan_o = scan_i;
    if (data_byte_i == CharSpace) begin
      if (scan_i.spaces != CountSat) begin
        scan_o.spaces = scan_i.spaces + 2'd1;
      end
    end else if (scan_i.spaces == 2'd1) begin
      if (data_byte_i == CharColon) begin
        if (scan_i.colons != CountSat) begin
          scan_o.colons = scan_i.colons + 2'd1;
        end
      end else if (scan_i.colons == 2'd1) begin
        // Only the field between the first and second colon is judged.
        scan_o.flag = (scan_i.flag == FlagEmpty && data_byte_i == CharFlag) ? FlagY : FlagOther;
      end
    end
  end

  assign drop_cur_o = flag_set(scan_i);
  assign drop_nxt_o = flag_set(scan_o);

endmodule

@@ design/fastq_filter_flag_dropper.sv @@
// FASTQ record filter: bytes of FASTQ text enter one per transfer and the bytes of kept records
// leave one per transfer, in order, with last set on the final output of each input byte. A
// record whose header has exactly one space and "Y" as the second colon-separated field after
// it is dropped whole. Header bytes are held in a 63-byte buffer as they enter; at the header's
// newline (or at stream end) a kept header is read back from that buffer, each byte read in
// state StRead and then sent in state StSend, and no input is taken meanwhile. Sequence,
// separator and quality bytes pass at one per cycle while the output is not stalled. A header
// longer than the buffer is sent out with header_overflow set and its record is kept. No
// clearing pass is needed after reset.
module fastq_filter_flag_dropper
  import fqd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  fqd_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output fqd_out_t out_data_o
);

  fqd_state_e state_q, state_d;
  logic [1:0] line_q, line_d;
  hdr_scan_t  scan_q, scan_d, scan_nxt;
  logic [HdrAw-1:0] len_q, len_d;
  logic drop_q, drop_d;
  logic unchk_q, unchk_d;
  logic [HdrAw-1:0] fl_cnt_q, fl_cnt_d, fl_idx_q, fl_idx_d;
  logic fl_ov_q, fl_ov_d;
  logic tail_en_q, tail_en_d;
  logic [7:0] tail_byte_q, tail_byte_d;
  logic out_valid_q, out_valid_d;
  fqd_out_t out_q, out_d;

  logic slot_free, acc, drop_cur, drop_nxt;
  logic mem_we, mem_re;
  logic [7:0] mem_rdata;
  logic [7:0] c;
  logic fl_final;

  assign c         = in_data_i.data_byte;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == StIdle) && slot_free);
  assign acc       = in_valid_i && !in_stall_o;
  assign fl_final  = (fl_idx_q == fl_cnt_q - HdrAw'(1));

  fqd_scan u_scan (
    .data_byte_i (c),
    .scan_i      (scan_q),
    .scan_o      (scan_nxt),
    .drop_cur_o  (drop_cur),
    .drop_nxt_o  (drop_nxt)
  );

  fqd_hdr_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (len_q),
    .wdata_i (c),
    .re_i    (mem_re),
    .raddr_i (fl_idx_q),
    .rdata_o (mem_rdata)
  );

  always_comb begin
    state_d     = state_q;
    line_d      = line_q;
    scan_d      = scan_q;
    len_d       = len_q;
    drop_d      = drop_q;
    unchk_d     = unchk_q;
    fl_cnt_d    = fl_cnt_q;
    fl_idx_d    = fl_idx_q;
    fl_ov_d     = fl_ov_q;
    tail_en_d   = tail_en_q;
    tail_byte_d = tail_byte_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (acc) begin
          if (line_q == 2'd0) begin
            if (unchk_q) begin
              out_valid_d = 1'b1;
              out_d       = '{out_byte: c, header_overflow: 1'b1, last: 1'b1};
              if (c == CharNl) begin
                unchk_d = 1'b0;
                drop_d  = 1'b0;
                line_d  = 2'd1;
                scan_d  = '0;
                len_d   = '0;
              end
            end else if (c == CharNl) begin
              if (drop_cur) begin
                drop_d = 1'b1;
              end else begin
                drop_d = 1'b0;
                if (len_q == '0) begin
                  out_valid_d = 1'b1;
                  out_d       = '{out_byte: CharNl, header_overflow: 1'b0, last: 1'b1};
                end else begin
                  fl_cnt_d    = len_q;
                  fl_idx_d    = '0;
                  fl_ov_d     = 1'b0;
                  tail_en_d   = 1'b1;
                  tail_byte_d = CharNl;
                  state_d     = StRead;
                end
              end
              line_d = 2'd1;
              scan_d = '0;
              len_d  = '0;
            end else if (len_q < HdrAw'(HdrBytes)) begin
              mem_we = 1'b1;
              len_d  = len_q + HdrAw'(1);
              scan_d = scan_nxt;
              // A header cut short by stream end is judged as if it had ended.
              if (in_data_i.stream_end && !drop_nxt) begin
                fl_cnt_d  = len_q + HdrAw'(1);
                fl_idx_d  = '0;
                fl_ov_d   = 1'b0;
                tail_en_d = 1'b0;
                state_d   = StRead;
              end
            end else begin
              fl_cnt_d    = len_q;
              fl_idx_d    = '0;
              fl_ov_d     = 1'b1;
              tail_en_d   = 1'b1;
              tail_byte_d = c;
              state_d     = StRead;
              unchk_d     = 1'b1;
              drop_d      = 1'b0;
              scan_d      = '0;
              len_d       = '0;
            end
          end else begin
            if (!drop_q) begin
              out_valid_d = 1'b1;
              out_d       = '{out_byte: c, header_overflow: 1'b0, last: 1'b1};
            end
            if (c == CharNl) begin
              line_d = line_q + 2'd1;
              if (line_q == 2'd3) begin
                drop_d = 1'b0;
              end
            end
          end
          if (in_data_i.stream_end) begin
            line_d  = '0;
            scan_d  = '0;
            len_d   = '0;
            drop_d  = 1'b0;
            unchk_d = 1'b0;
          end
        end
      end
      StRead: begin
        mem_re  = 1'b1;
        state_d = StSend;
      end
      StSend: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d = '{out_byte: mem_rdata, header_overflow: fl_ov_q,
                    last: fl_final && !tail_en_q};
          if (fl_final) begin
            state_d = tail_en_q ? StTail : StIdle;
          end else begin
            fl_idx_d = fl_idx_q + HdrAw'(1);
            state_d  = StRead;
          end
        end
      end
      StTail: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = '{out_byte: tail_byte_q, header_overflow: fl_ov_q, last: 1'b1};
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q      <= '0;
      scan_q      <= '0;
      len_q       <= '0;
      drop_q      <= 1'b0;
      unchk_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      line_q      <= line_d;
      scan_q      <= scan_d;
      len_q       <= len_d;
      drop_q      <= drop_d;
      unchk_q     <= unchk_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fl_cnt_q    <= fl_cnt_d;
    fl_idx_q    <= fl_idx_d;
    fl_ov_q     <= fl_ov_d;
    tail_en_q   <= tail_en_d;
    tail_byte_q <= tail_byte_d;
    out_q       <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ design/fqd_checker.sv @@
module fqd_checker
  import fqd_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input fqd_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input fqd_out_t out_data_o
);

  // A held result keeps its value until the transfer completes.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output changed");

  // No input is taken while the output register is full and held.
  a_no_take_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input taken while output blocked");

  // While a header is being sent out, the input side waits.
  a_no_take_mid_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last |-> in_stall_o)
    else $error("input taken before last output of previous byte");

  // An input is accepted only while the output slot is free.
  a_accept_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> !out_valid_o || !out_stall_i)
    else $error("input accepted while output blocked");

endmodule

bind fastq_filter_flag_dropper fqd_checker u_fqd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

@@ dv/fqd_checker.sv @@
`timescale 1ns / 100ps

module fqd_tb_checker
  import fqd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  logic     in_stall_i,
  input  fqd_in_t  in_data_i,
  input  logic     out_valid_i,
  input  logic     out_stall_i,
  input  fqd_out_t out_data_i,
  output int       error_count_o,
  output int       pending_o
);

  // Shadow of the filter's parsing state.
  logic [1:0]        line_idx;
  logic [1:0]        n_spaces;
  logic [1:0]        n_colons;
  flag_e             field_flag;
  logic [7:0]        hdr_buf [HdrBytes];
  logic [HdrAw-1:0]  hdr_len;
  logic              drop_rec;
  logic              pass_raw;

  fqd_out_t kept_bytes[$];
  int       mismatches;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH at %0t: %s got 'h%0h want 'h%0h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic emit(input logic [7:0] b, input logic ov);
    fqd_out_t r;
    r.out_byte        = b;
    r.header_overflow = ov;
    r.last            = 1'b0;
    kept_bytes.insert(kept_bytes.size(), r);
  endtask

  task automatic flush_header(input logic ov);
    for (int i = 0; i < int'(hdr_len); i++) begin
      emit(hdr_buf[i], ov);
    end
  endtask

  task automatic clear_scan();
    n_spaces   = '0;
    n_colons   = '0;
    field_flag = FlagEmpty;
    hdr_len    = '0;
  endtask

  task automatic clear_all();
    line_idx = '0;
    clear_scan();
    drop_rec = 1'b0;
    pass_raw = 1'b0;
  endtask

  // Tracks the space count, the colons after the first space and the
  // contents of the field that follows the first such colon.
  task automatic scan_byte(input logic [7:0] c);
    if (c == CharSpace) begin
      if (n_spaces < CountSat) n_spaces++;
    end else if (n_spaces == 2'd1) begin
      if (c == CharColon) begin
        if (n_colons < CountSat) n_colons++;
      end else if (n_colons == 2'd1) begin
        field_flag = (field_flag == FlagEmpty && c == CharFlag) ? FlagY : FlagOther;
      end
    end
  endtask

  function automatic logic header_flagged();
    return n_spaces == 2'd1 && n_colons >= 2'd1 && field_flag == FlagY;
  endfunction

  task automatic predict_byte(input fqd_in_t item);
    int       start;
    fqd_out_t tail_r;
    start = kept_bytes.size();
    if (line_idx == 2'd0) begin
      if (pass_raw) begin
        emit(item.data_byte, 1'b1);
        if (item.data_byte == CharNl) begin
          pass_raw = 1'b0;
          drop_rec = 1'b0;
          line_idx = 2'd1;
          clear_scan();
        end
      end else if (item.data_byte == CharNl) begin
        if (header_flagged()) begin
          drop_rec = 1'b1;
        end else begin
          drop_rec = 1'b0;
          flush_header(1'b0);
          emit(CharNl, 1'b0);
        end
        line_idx = 2'd1;
        clear_scan();
      end else if (int'(hdr_len) < HdrBytes) begin
        hdr_buf[hdr_len] = item.data_byte;
        hdr_len++;
        scan_byte(item.data_byte);
      end else begin
        // Buffer full: everything so far goes out flagged, unchecked.
        flush_header(1'b1);
        emit(item.data_byte, 1'b1);
        pass_raw = 1'b1;
        drop_rec = 1'b0;
        clear_scan();
      end
    end else begin
      if (!drop_rec) emit(item.data_byte, 1'b0);
      if (item.data_byte == CharNl) begin
        line_idx = line_idx + 2'd1;
        if (line_idx == 2'd0) drop_rec = 1'b0;
      end
    end

    if (item.stream_end) begin
      if (line_idx == 2'd0 && !pass_raw && hdr_len != '0 && !header_flagged()) begin
        flush_header(1'b0);
      end
      clear_all();
    end

    if (kept_bytes.size() > start) begin
      tail_r      = kept_bytes.pop_back();
      tail_r.last = 1'b1;
      kept_bytes.insert(kept_bytes.size(), tail_r);
    end
  endtask

  task automatic check_output(input fqd_out_t got);
    fqd_out_t want;
    if (kept_bytes.size() == 0) begin
      report_mismatch("output byte with nothing expected", got.out_byte, 0);
    end else begin
      want = kept_bytes.pop_front();
      if (got.out_byte != want.out_byte) begin
        report_mismatch("out_byte", got.out_byte, want.out_byte);
      end
      if (got.header_overflow != want.header_overflow) begin
        report_mismatch("header_overflow", got.header_overflow, want.header_overflow);
      end
      if (got.last != want.last) begin
        report_mismatch("last", got.last, want.last);
      end
    end
  endtask

  // Inputs are predicted before outputs are checked so that a byte caused
  // by a transfer at the same edge would still find its expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_all();
      kept_bytes.delete();
      mismatches = 0;
      error_count_o <= 0;
      pending_o     <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) predict_byte(in_data_i);
      if (out_valid_i && !out_stall_i) check_output(out_data_i);
      error_count_o <= mismatches;
      pending_o     <= kept_bytes.size();
    end
  end

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;
  import fqd_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int RandomBytes = 100;
  // Leave margin beyond the longest header read-back.
  localparam int DrainCycles = 200;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  fqd_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  fqd_out_t out_data;
  int       error_count;
  int       pending;
  int       cycle_count = 0;
  bit       no_gaps = 1'b0;

  fqd_in_t  text_q[$];

  fastq_filter_flag_dropper DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  fqd_tb_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .error_count_o(error_count),
    .pending_o    (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_len(input int zero_pct, input int long_max);
    int r;
    r = $urandom_range(0, 99);
    if (r < zero_pct) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, long_max);
  endfunction

  // Receiver back-pressure; lengths are at least one so each step sees a
  // single assignment to the stall.
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : pick_len(0, 12) + 1;
      out_stall <= 1'b0;
      repeat (n) @(posedge clk);
      n = pick_len(0, 30);
      if (n == 0) n = 1;
      out_stall <= 1'b1;
      repeat (n) @(posedge clk);
    end
  end

  task automatic drive_item(input fqd_in_t item);
    int gap;
    gap = no_gaps ? 0 : pick_len(55, 25);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_text();
    foreach (text_q[i]) drive_item(text_q[i]);
    text_q.delete();
  endtask

  task automatic push_raw(input logic [7:0] b);
    fqd_in_t it;
    it.data_byte  = b;
    it.stream_end = 1'b0;
    text_q.insert(text_q.size(), it);
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_raw(s[i]);
  endtask

  task automatic mark_end();
    fqd_in_t it;
    it            = text_q.pop_back();
    it.stream_end = 1'b1;
    text_q.insert(text_q.size(), it);
  endtask

  // Any byte but a newline.
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 254));
    if (b >= CharNl) b++;
    return b;
  endfunction

  task automatic push_line(input int n);
    repeat (n) push_raw(text_byte());
    push_raw(CharNl);
  endtask

  task automatic push_name();
    push_raw("@");
    repeat ($urandom_range(1, 4)) push_raw(8'(8'd65 + $urandom_range(0, 25)));
  endtask

  task automatic push_header();
    int kind;
    kind = $urandom_range(0, 19);
    push_name();
    if (kind <= 5) begin
      if ($urandom_range(0, 3) == 0) push_str(":7");
      push_raw(CharSpace);
      push_raw(8'(8'd48 + $urandom_range(0, 9)));
      push_str(":Y");
      if ($urandom_range(0, 1) == 1) push_str(":0:ACGT");
    end else if (kind <= 10) begin
      push_raw(CharSpace);
      push_raw(8'(8'd48 + $urandom_range(0, 9)));
      push_raw(CharColon);
      case ($urandom_range(0, 4))
        0: push_str("N");
        1: push_str("YY");
        2: push_str("y");
        3: push_str("Yn");
        default: ;
      endcase
      if ($urandom_range(0, 1) == 1) push_str(":0");
    end else if (kind <= 17) begin
      repeat ($urandom_range(0, 10)) begin
        case ($urandom_range(0, 5))
          0: push_raw(CharSpace);
          1: push_raw(CharColon);
          2: push_raw(CharFlag);
          3: push_raw("N");
          4: push_raw("0");
          default: push_raw(text_byte());
        endcase
      end
    end else begin
      // Long enough to land around the buffer depth, often over it.
      repeat ($urandom_range(58, 66)) push_raw(8'(8'd97 + $urandom_range(0, 25)));
      if ($urandom_range(0, 1) == 1) push_str(" 1:Y");
    end
    push_raw(CharNl);
  endtask

  task automatic push_record();
    int len;
    int rec_start;
    int cut;
    rec_start = text_q.size();
    push_header();
    len = $urandom_range(1, 6);
    push_line(len);
    push_raw("+");
    push_raw(CharNl);
    push_line(len);
    if ($urandom_range(0, 14) == 0) begin
      // Broken record: the stream stops partway through.
      cut = $urandom_range(1, text_q.size() - rec_start - 1);
      repeat (cut) void'(text_q.pop_back());
      mark_end();
    end else if ($urandom_range(0, 7) == 0) begin
      mark_end();
    end
  endtask

  task automatic push_noise();
    repeat ($urandom_range(1, 12)) push_raw(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 1) == 1) mark_end();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int sent;
    bit paused;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed records.
    push_str("@a 1:Y:0\nACGT\n+\nIIII\n");
    push_str("@a 1:N:0\nAC\n+\nII\n");
    push_str("@ab\nA\n+\nI\n");
    push_str("@a b 1:Y\nA\n+\nI\n");
    push_str("@a 1Y\nA\n+\nI\n");
    push_str("@x:y 2:Y\nA\n+\nI\n");
    push_str("@a 1::Y\nA\n+\nI\n");
    push_str("@a 1:Y\r\nA\r\n+\r\nI\r\n");
    push_str("\n");
    push_raw(8'h00);
    push_raw(8'hFF);
    push_raw(8'h80);
    push_str("\n+\nI\n");
    push_raw("@");
    repeat (HdrBytes - 1) push_raw("h");
    push_str("\nA\n+\nI\n");
    push_raw("@");
    repeat (HdrBytes + 6) push_raw("o");
    push_str(" 1:Y\nA\n+\nI\n");
    push_str("@a 1:N");
    mark_end();
    push_str("@b 1:Y");
    mark_end();
    push_str("@c\nAC");
    mark_end();
    send_text();

    // Let everything drain before the random part.
    wait_drained();

    sent = 0;
    paused = 1'b0;
    while (sent < RandomBytes) begin
      if ($urandom_range(0, 5) == 0) no_gaps = ~no_gaps;
      if ($urandom_range(0, 9) == 0) push_noise();
      else push_record();
      sent += text_q.size();
      send_text();
      if (!paused && sent > RandomBytes / 2) begin
        paused = 1'b1;
        wait_drained();
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    if (error_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
